// File: hdl/bary_pkg.sv
// Package for barycentric_coordinates_2d: constants and request types.
package bary_pkg;

  localparam int CoordBitsDefault = 16;
  localparam int FracBitsDefault  = 16;
  localparam int WeightBits       = 32;
  localparam int QueueDepth       = 4;

  // Front stage result handed to the back end: numerators and denominator.
  // Widths cover the largest COORD_BITS (24): products need 2*(C+1)+1 bits.
  localparam int ProdMax = 2 * (24 + 1) + 1;

  typedef struct packed {
    logic signed [ProdMax-1:0] num0;
    logic signed [ProdMax-1:0] num1;
    logic signed [ProdMax-1:0] den;
  } bary_req_t;

endpackage

// File: hdl/bary_front.sv
// Front end: edge differences, then products, registered into a request.
module bary_front import bary_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output logic                         req_valid,
  input  logic                         req_ready,
  output bary_req_t                    req
);

  localparam int DW = COORD_BITS + 1;

  // stage 1: differences
  logic signed [DW-1:0] d_y0y2, d_x1x2, d_y1y2, d_x2x0, d_pyy2, d_x2px, d_pyy0, d_x0px;
  logic                 s1_valid;
  logic                 s1_ready;

  assign s1_ready = !req_valid || req_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      d_y0y2 <= DW'(y0) - DW'(y2);
      d_x1x2 <= DW'(x1) - DW'(x2);
      d_y1y2 <= DW'(y1) - DW'(y2);
      d_x2x0 <= DW'(x2) - DW'(x0);
      d_pyy2 <= DW'(py) - DW'(y2);
      d_x2px <= DW'(x2) - DW'(px);
      d_pyy0 <= DW'(py) - DW'(y0);
      d_x0px <= DW'(x0) - DW'(px);
    end
  end

  // stage 2: products (25x25 at most) and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s1_ready) begin
      req_valid <= s1_valid;
    end
    if (s1_ready && s1_valid) begin
      req.den  <= ProdMax'(d_y0y2 * d_x1x2) + ProdMax'(d_y1y2 * d_x2x0);
      req.num0 <= ProdMax'(d_pyy2 * d_x1x2) + ProdMax'(d_y1y2 * d_x2px);
      req.num1 <= ProdMax'(d_pyy0 * d_x2x0) - ProdMax'(d_y0y2 * d_x0px);
    end
  end

endmodule

// File: hdl/bary_queue.sv
// Small FIFO of requests between front and back ends.
module bary_queue import bary_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  bary_req_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output bary_req_t rd_data
);

  localparam int AW = $clog2(QueueDepth);

  bary_req_t     slots [QueueDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          push, pop;

  assign wr_ready = count != (AW+1)'(QueueDepth);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) slots[wr_ptr] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(QueueDepth))
    else $error("queue overfill");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> count != '0)
    else $error("queue push lost");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr)) else $error("queue pointers disagree");

endmodule

// File: hdl/bary_divider.sv
// Pipelined restoring divider: one quotient bit per stage, two in parallel.
module bary_divider import bary_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bary_req_t                 req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [WeightBits-1:0] weight0,
  output logic signed [WeightBits-1:0] weight1,
  output logic signed [WeightBits-1:0] weight2,
  output logic                      degenerate,
  output logic                      saturated
);

  localparam int MW = ProdMax;              // magnitude width
  localparam int QB = WeightBits + 1;       // quotient bits kept, caps at 2^32
  localparam int NS = QB;                   // one stage per quotient bit

  // Dividend is an << FRAC_BITS; quotient >= 2^32 is capped.
  // Each stage: compare remainder against ad << (QB-1-k).
  localparam int RW = MW + FRAC_BITS + 1;

  typedef struct packed {
    logic          valid;
    logic          neg0;
    logic          neg1;
    logic          degen;
    logic          ovf0;
    logic          ovf1;
    logic [RW-1:0] rem0;
    logic [RW-1:0] rem1;
    logic [RW-1:0] ad;
    logic [QB-1:0] q0;
    logic [QB-1:0] q1;
  } dstage_t;

  dstage_t st [NS+1];
  logic    adv;

  // final output register
  logic fin_valid;
  assign adv      = !fin_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = fin_valid;

  logic [MW-1:0] an0, an1, adm;
  always_comb begin
    an0 = req.num0[MW-1] ? MW'(-req.num0) : MW'(req.num0);
    an1 = req.num1[MW-1] ? MW'(-req.num1) : MW'(req.num1);
    adm = req.den[MW-1]  ? MW'(-req.den)  : MW'(req.den);
  end

  // stage 0: load magnitudes and signs; overflow is found by the first bit stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (adv) begin
      st[0].valid <= in_valid;
    end
    if (adv) begin
      st[0].neg0  <= req.num0[MW-1] ^ req.den[MW-1];
      st[0].neg1  <= req.num1[MW-1] ^ req.den[MW-1];
      st[0].degen <= req.den == '0;
      st[0].ovf0  <= 1'b0;
      st[0].ovf1  <= 1'b0;
      st[0].rem0  <= RW'(an0) << FRAC_BITS;
      st[0].rem1  <= RW'(an1) << FRAC_BITS;
      st[0].ad    <= RW'(adm);
      st[0].q0    <= '0;
      st[0].q1    <= '0;
    end
  end

  // Quotient bits QB-1 .. 0 of (an<<F)/ad; bit QB-1 set means >= 2^32 (capped).
  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [RW+QB-1:0] dsh;
    logic             t0, t1;
    dstage_t          nxt;
    assign dsh = (RW+QB)'(st[k].ad) << SH;
    assign t0  = (RW+QB)'(st[k].rem0) >= dsh;
    assign t1  = (RW+QB)'(st[k].rem1) >= dsh;
    always_comb begin
      nxt = st[k];
      if (t0 && !st[k].ovf0) begin
        if (k == 0) begin
          nxt.ovf0 = 1'b1;
        end else begin
          nxt.rem0 = st[k].rem0 - RW'(dsh);
          nxt.q0   = st[k].q0 | (QB'(1) << SH);
        end
      end
      if (t1 && !st[k].ovf1) begin
        if (k == 0) begin
          nxt.ovf1 = 1'b1;
        end else begin
          nxt.rem1 = st[k].rem1 - RW'(dsh);
          nxt.q1   = st[k].q1 | (QB'(1) << SH);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].valid <= 1'b0;
      end else if (adv) begin
        st[k+1] <= nxt;
      end
    end
  end

  // Sign, clamp, third weight
  localparam logic signed [WeightBits+2:0] MaxW = 35'sd2147483647;
  localparam logic signed [WeightBits+2:0] MinW = -35'sd2147483648;
  localparam logic signed [WeightBits+2:0] One  = (WeightBits+3)'(1) <<< FRAC_BITS;

  logic signed [WeightBits+2:0] m0, m1, s0, s1, c0, c1, s2, c2;
  logic                         sat_any;
  dstage_t                      fs;
  assign fs = st[NS];

  always_comb begin
    m0 = fs.ovf0 ? ((WeightBits+3)'(1) <<< WeightBits) : (WeightBits+3)'(fs.q0);
    m1 = fs.ovf1 ? ((WeightBits+3)'(1) <<< WeightBits) : (WeightBits+3)'(fs.q1);
    s0 = fs.neg0 ? -m0 : m0;
    s1 = fs.neg1 ? -m1 : m1;
    c0 = s0 > MaxW ? MaxW : (s0 < MinW ? MinW : s0);
    c1 = s1 > MaxW ? MaxW : (s1 < MinW ? MinW : s1);
    s2 = One - c0 - c1;
    c2 = s2 > MaxW ? MaxW : (s2 < MinW ? MinW : s2);
    sat_any = (c0 != s0) || (c1 != s1) || (c2 != s2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= fs.valid;
    end
    if (adv) begin
      degenerate <= fs.degen;
      saturated  <= fs.degen ? 1'b0 : sat_any;
      weight0    <= fs.degen ? '0 : WeightBits'(c0);
      weight1    <= fs.degen ? '0 : WeightBits'(c1);
      weight2    <= fs.degen ? '0 : WeightBits'(c2);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (weight0 == '0 && !saturated)) else $error("degen weights");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(weight0)) else $error("result changed");

endmodule

// File: hdl/barycentric_coordinates_2d.sv
// Path of a request: 2 front stages, the queue's slot register, 34 divider stages
// (load plus 33 quotient bits) and 1 output register.
// Throughput: one request per cycle while the output is not stalled; one quotient
// bit per divider stage, so any stall at the output freezes the whole back end.
// The queue lets the front keep taking requests while the back end is held.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
module barycentric_coordinates_2d import bary_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDefault,
  parameter int FRAC_BITS  = FracBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] vert0_x,
  input  logic signed [COORD_BITS-1:0] vert0_y,
  input  logic signed [COORD_BITS-1:0] vert1_x,
  input  logic signed [COORD_BITS-1:0] vert1_y,
  input  logic signed [COORD_BITS-1:0] vert2_x,
  input  logic signed [COORD_BITS-1:0] vert2_y,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WeightBits-1:0] weight0,
  output logic signed [WeightBits-1:0] weight1,
  output logic signed [WeightBits-1:0] weight2,
  output logic                         degenerate,
  output logic                         saturated
);

  bary_req_t f_req, q_req;
  logic      f_valid, f_ready, q_valid, q_ready;

  bary_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready,
    .x0(vert0_x), .y0(vert0_y), .x1(vert1_x), .y1(vert1_y),
    .x2(vert2_x), .y2(vert2_y), .px(point_x), .py(point_y),
    .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
  );

  bary_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
  );

  bary_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .in_valid(q_valid), .in_ready(q_ready), .req(q_req),
    .out_valid, .out_ready, .weight0, .weight1, .weight2, .degenerate, .saturated
  );

endmodule

// File: tb/bary_checker.sv
// Checker for barycentric_coordinates_2d: predicts weights per request and compares.
module bary_checker import bary_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDefault,
  parameter int FRAC_BITS  = FracBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] vert0_x,
  input  logic signed [COORD_BITS-1:0] vert0_y,
  input  logic signed [COORD_BITS-1:0] vert1_x,
  input  logic signed [COORD_BITS-1:0] vert1_y,
  input  logic signed [COORD_BITS-1:0] vert2_x,
  input  logic signed [COORD_BITS-1:0] vert2_y,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [WeightBits-1:0] weight0,
  input  logic signed [WeightBits-1:0] weight1,
  input  logic signed [WeightBits-1:0] weight2,
  input  logic                         degenerate,
  input  logic                         saturated,
  output int                           fail_count,
  output int                           pending,
  output int                           degen_seen,
  output int                           sat_seen
);

  typedef struct {
    logic signed [WeightBits-1:0] w0, w1, w2;
    logic degen, sat;
  } weights_t;

  weights_t weights_due[$];

  // Exact quotient with FRAC_BITS fraction bits, truncated toward zero;
  // huge magnitudes are capped at 2^32 so the clamp below catches them.
  function automatic longint fixed_quot(longint num, longint den);
    longint an, ad, q, r, mag;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = an / ad;
    r = an % ad;
    if (q >= (longint'(1) << (32 - FRAC_BITS))) mag = longint'(1) << 32;
    else mag = (q << FRAC_BITS) | ((r << FRAC_BITS) / ad);
    return ((num < 0) != (den < 0)) ? -mag : mag;
  endfunction

  function automatic longint clamp_w(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic weights_t predict_weights(longint x0, longint y0, longint x1,
                                               longint y1, longint x2, longint y2,
                                               longint px, longint py);
    weights_t e;
    longint den, n0, n1, a, b;
    logic sat;
    den = (y0 - y2) * (x1 - x2) + (y1 - y2) * (x2 - x0);
    n0 = (py - y2) * (x1 - x2) + (y1 - y2) * (x2 - px);
    n1 = (py - y0) * (x2 - x0) + (y2 - y0) * (x0 - px);
    sat = 1'b0;
    e.degen = (den == 0);
    if (e.degen) begin
      e.w0 = '0; e.w1 = '0; e.w2 = '0; e.sat = 1'b0;
      return e;
    end
    a = clamp_w(fixed_quot(n0, den), sat);
    b = clamp_w(fixed_quot(n1, den), sat);
    e.w0 = a[31:0];
    e.w1 = b[31:0];
    a = clamp_w((longint'(1) << FRAC_BITS) - a - b, sat);
    e.w2 = a[31:0];
    e.sat = sat;
    return e;
  endfunction

  assign pending = weights_due.size();

  always @(posedge clk) begin
    weights_t e;
    if (rst) begin
      fail_count <= 0;
      degen_seen <= 0;
      sat_seen <= 0;
    end else begin
      if (in_valid && in_ready)
        weights_due.push_back(predict_weights(vert0_x, vert0_y, vert1_x, vert1_y,
                                              vert2_x, vert2_y, point_x, point_y));
      if (out_valid && out_ready) begin
        if (weights_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = weights_due.pop_front();
          if (degenerate) degen_seen <= degen_seen + 1;
          if (saturated) sat_seen <= sat_seen + 1;
          if (weight0 !== e.w0 || weight1 !== e.w1 || weight2 !== e.w2 ||
              degenerate !== e.degen || saturated !== e.sat) begin
            if (weight0 !== e.w0) $error("weight0 exp %0d got %0d", e.w0, weight0);
            if (weight1 !== e.w1) $error("weight1 exp %0d got %0d", e.w1, weight1);
            if (weight2 !== e.w2) $error("weight2 exp %0d got %0d", e.w2, weight2);
            if (degenerate !== e.degen)
              $error("degenerate exp %0b got %0b", e.degen, degenerate);
            if (saturated !== e.sat)
              $error("saturated exp %0b got %0b", e.sat, saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the barycentric_coordinates_2d testbench: clock, stimulus and verdict.
module testbench;
  import bary_pkg::*;

  localparam int CB = CoordBitsDefault;
  localparam int NumRandom = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, degenerate, saturated;
  logic signed [CB-1:0] vert0_x = '0, vert0_y = '0, vert1_x = '0, vert1_y = '0;
  logic signed [CB-1:0] vert2_x = '0, vert2_y = '0, point_x = '0, point_y = '0;
  logic signed [WeightBits-1:0] weight0, weight1, weight2;
  int fail_count, pending, degen_seen, sat_seen;
  logic drain_phase = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  barycentric_coordinates_2d dut (.*);
  bary_checker chk (.*);

  function automatic logic signed [CB-1:0] rand_coord(int spread);
    case ($urandom_range(0, 3))
      0: return CB'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return CB'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  // Present one request, hold until accepted; sometimes an idle burst ahead of it.
  // in_ready is checked at the falling edge, where it is settled.
  task automatic send_tri(input logic signed [CB-1:0] c[8]);
    if (!drain_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {vert0_x, vert0_y, vert1_x, vert1_y} <= {c[0], c[1], c[2], c[3]};
    {vert2_x, vert2_y, point_x, point_y} <= {c[4], c[5], c[6], c[7]};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Output side stalls in bursts, none once draining starts.
  initial begin
    @(negedge rst);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!drain_phase) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    logic signed [CB-1:0] c[8];
    int spread;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // right triangle with legs of 16, points inside, on vertex, outside
    c = '{0, 0, 16, 0, 0, 16, 4, 4};       send_tri(c);
    c = '{0, 0, 16, 0, 0, 16, 0, 0};       send_tri(c);
    c = '{0, 0, 16, 0, 0, 16, -50, 90};    send_tri(c);
    // degenerate: collinear and coincident vertices
    c = '{1, 1, 2, 2, 3, 3, 7, -7};        send_tri(c);
    c = '{5, 5, 5, 5, 5, 5, 5, 5};         send_tri(c);
    // tiny triangle, far point: saturation
    c = '{0, 0, 1, 0, 0, 1, 32767, 32767}; send_tri(c);
    c = '{0, 0, 1, 0, 0, 1, -32768, -32768}; send_tri(c);
    c = '{0, 0, 1, 0, 0, 1, 32767, -32768};  send_tri(c);
    // full-range extremes
    c = '{-32768, -32768, 32767, -32768, -32768, 32767, 0, 0}; send_tri(c);
    c = '{32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768}; send_tri(c);
    c = '{-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768}; send_tri(c);
    c = '{-1, -1, -1, -1, -1, -1, -1, -1}; send_tri(c);
    // clockwise winding, then one more counter-clockwise triangle
    c = '{0, 0, 0, 16, 16, 0, 3, 9};       send_tri(c);
    c = '{0, 0, 3, 0, 0, 7, 1, 1};         send_tri(c);
    for (int i = 0; i < NumRandom; i++) begin
      spread = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 200);
      if (i > NumRandom - 100) drain_phase = 1'b1;
      foreach (c[k]) c[k] = rand_coord(spread);
      if ($urandom_range(0, 15) == 0) begin
        c[4] = c[2]; c[5] = c[3];  // force zero area
      end
      send_tri(c);
    end
    drain_phase = 1'b1;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d triangles: %0d degenerate, %0d saturated results seen.",
             NumRandom + 14, degen_seen, sat_seen);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
